>>> rtl/core/ltps_pkg.sv
// Shared types and constants of the least-time peer selector.
package ltps_pkg;

    localparam int DEFAULT_MAX_PEERS = 32;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [1:0] {
        CMD_HEALTH = 2'd0,
        CMD_METRIC = 2'd1,
        CMD_SELECT = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_CHOSEN   = 2'd1,
        ST_BUSY     = 2'd2,
        ST_FALLBACK = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_METRIC_BASE = 2'd0,
        CFG_METRIC_MODE = 2'd1,
        CFG_PEER_COUNT  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } seq_state_t;

    // Write request from the sequencer to the peer table.
    typedef struct packed {
        logic        health_we;
        logic        metric_we;
        logic [4:0]  peer_index;
        logic        peer_down;
        logic [7:0]  fail_limit;
        logic [7:0]  fail_count;
        logic [31:0] fail_hold;
        logic [31:0] time_stamp;
        logic [1:0]  metric_kind;
        logic [31:0] metric_value;
    } peer_wr_t;

    // Registered scan answer of the peer table for one peer.
    typedef struct packed {
        logic        usable;
        logic [31:0] time_val;
    } peer_rsp_t;

endpackage

>>> rtl/core/ltps_if.sv
// Handshake channels for command beats and result beats.
interface ltps_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  peer_index;
    logic        peer_down;
    logic [7:0]  fail_limit;
    logic [7:0]  fail_count;
    logic [31:0] fail_hold;
    logic [31:0] time_stamp;
    logic [1:0]  metric_kind;
    logic [31:0] metric_value;
    logic [31:0] tried_mask;

    modport source (
        output valid, command, peer_index, peer_down, fail_limit, fail_count,
               fail_hold, time_stamp, metric_kind, metric_value, tried_mask,
        input  ready
    );
    modport sink (
        input  valid, command, peer_index, peer_down, fail_limit, fail_count,
               fail_hold, time_stamp, metric_kind, metric_value, tried_mask,
        output ready
    );
endinterface

interface ltps_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  chosen_index;
    logic [31:0] chosen_time;
    logic [31:0] chosen_conns;
    logic [31:0] tried_out;

    modport source (
        output valid, status, chosen_index, chosen_time, chosen_conns, tried_out,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_index, chosen_time, chosen_conns, tried_out,
        output ready
    );
endinterface

>>> rtl/core/ltps_peer_table.sv
// Peer table: health records, latency metric memory and connection counters.
module ltps_peer_table
    import ltps_pkg::*;
#(
    parameter int PEER_DEPTH = DEFAULT_MAX_PEERS
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  peer_wr_t                      wr,
    input  logic [$clog2(PEER_DEPTH)-1:0] rd_index,
    input  logic [1:0]                    rd_kind,
    input  logic [31:0]                   now,
    output peer_rsp_t                     rsp,
    input  logic [$clog2(PEER_DEPTH)-1:0] conn_index,
    input  logic                          conn_inc,
    output logic [31:0]                   conn_value
);

    localparam int IW = $clog2(PEER_DEPTH);
    localparam int TDEPTH = PEER_DEPTH * 4;

    logic            down_reg [PEER_DEPTH];
    logic [7:0]      lim_reg  [PEER_DEPTH];
    logic [7:0]      cnt_reg  [PEER_DEPTH];
    logic [31:0]     win_reg  [PEER_DEPTH];
    logic [31:0]     chk_reg  [PEER_DEPTH];
    logic [31:0]     conn_reg [PEER_DEPTH];
    logic [31:0]     time_mem [TDEPTH];
    logic [TDEPTH-1:0] time_vld_reg;

    logic [31:0] rd_data_reg;
    logic        rd_vld_reg;
    logic        usable_reg;

    logic          wr_hit;
    logic [IW-1:0] wr_idx;
    logic [IW+1:0] wr_addr;
    logic [IW+1:0] rd_addr;
    logic          failed_out;
    logic [31:0]   elapsed;

    assign wr_hit  = ({1'b0, wr.peer_index} < 6'(PEER_DEPTH));
    assign wr_idx  = wr.peer_index[IW-1:0];
    assign wr_addr = {wr_idx, wr.metric_kind};
    assign rd_addr = {rd_index, rd_kind};

    // Elapsed time wraps modulo 2^32 like the timestamps themselves.
    assign elapsed    = now - chk_reg[rd_index];
    assign failed_out = (lim_reg[rd_index] != 8'd0)
                     && (cnt_reg[rd_index] >= lim_reg[rd_index])
                     && (elapsed <= win_reg[rd_index]);

    assign conn_value = conn_reg[conn_index];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PEER_DEPTH; i++)
            begin
                down_reg[i] <= 1'b0;
                lim_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                win_reg[i]  <= '0;
                chk_reg[i]  <= '0;
                conn_reg[i] <= '0;
            end
            time_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            usable_reg   <= 1'b0;
        end
        else
        begin
            if (wr.health_we && wr_hit)
            begin
                down_reg[wr_idx] <= wr.peer_down;
                lim_reg[wr_idx]  <= wr.fail_limit;
                cnt_reg[wr_idx]  <= wr.fail_count;
                win_reg[wr_idx]  <= wr.fail_hold;
                chk_reg[wr_idx]  <= wr.time_stamp;
            end
            if (wr.metric_we && wr_hit)
            begin
                time_vld_reg[wr_addr] <= 1'b1;
            end
            if (conn_inc && (conn_reg[conn_index] != 32'hFFFF_FFFF))
            begin
                conn_reg[conn_index] <= conn_reg[conn_index] + 32'd1;
            end
            rd_vld_reg <= time_vld_reg[rd_addr];
            usable_reg <= !down_reg[rd_index] && !failed_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.metric_we && wr_hit)
        begin
            time_mem[wr_addr] <= wr.metric_value;
        end
        rd_data_reg <= time_mem[rd_addr];
    end

    // A metric that was never written reads as zero.
    assign rsp.usable   = usable_reg;
    assign rsp.time_val = rd_vld_reg ? rd_data_reg : 32'd0;

endmodule

>>> rtl/core/least_time_peer_selector_unit.sv
// Least-time peer selector: command sequencer, peer scan and result register.
// Health and metric writes and fallback selects go to the finish state, which
// loads the result once the result port is free; the next beat is accepted in
// the cycle after that load. A select scans the peers one per cycle through
// the shared compare unit, n = min(peer_count, MAX_PEERS, 32) of them, then
// drains. Reset clears control state, health, counters and metric valid bits.
module least_time_peer_selector_unit
    import ltps_pkg::*;
#(
    parameter int MAX_PEERS = DEFAULT_MAX_PEERS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    ltps_cmd_if.sink               cmd,
    ltps_res_if.source             res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PEER_DEPTH = (MAX_PEERS < 32) ? MAX_PEERS : 32;
    localparam int IW = $clog2(PEER_DEPTH);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic        metric_base_reg;
    logic        metric_mode_reg;
    logic [5:0]  peer_count_reg;
    logic        first_done_reg;

    logic        scan_op_reg;
    status_t     status_reg;
    logic [31:0] tried_reg;
    logic [31:0] stamp_reg;
    logic [1:0]  kind_reg;
    logic [IW-1:0] scan_reg;
    logic [IW-1:0] last_reg;
    logic [IW-1:0] scan_idx_prev_reg;
    logic        pipe_vld_reg;
    logic        found_reg;
    logic [IW-1:0] best_reg;
    logic [31:0] best_time_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [4:0]  out_index_reg;
    logic [31:0] out_time_reg;
    logic [31:0] out_conns_reg;
    logic [31:0] out_tried_reg;

    peer_wr_t    wr;
    peer_rsp_t   rsp;
    logic [31:0] conn_value;
    logic [31:0] conn_new;

    logic        accept;
    logic        fallback;
    logic [5:0]  scan_count;
    logic        last_issue;
    logic        better;
    logic        load_out;
    logic        conn_inc;

    assign accept     = cmd.valid && cmd.ready;
    assign fallback   = (peer_count_reg <= 6'd1) || !first_done_reg;
    assign scan_count = (peer_count_reg > 6'(PEER_DEPTH)) ? 6'(PEER_DEPTH) : peer_count_reg;
    assign last_issue = (scan_reg == last_reg);
    assign load_out   = (state_reg == S_FINISH) && (!out_valid_reg || res.ready);
    assign conn_inc   = load_out && scan_op_reg && found_reg;
    assign conn_new   = (conn_value == 32'hFFFF_FFFF) ? conn_value : conn_value + 32'd1;

    // Shared compare unit: one candidate per cycle against the running best.
    assign better = pipe_vld_reg && rsp.usable
                 && (!found_reg || (rsp.time_val < best_time_reg));

    always_comb
    begin
        wr.health_we    = accept && (cmd.command == CMD_HEALTH);
        wr.metric_we    = accept && (cmd.command == CMD_METRIC);
        wr.peer_index   = cmd.peer_index;
        wr.peer_down    = cmd.peer_down;
        wr.fail_limit   = cmd.fail_limit;
        wr.fail_count   = cmd.fail_count;
        wr.fail_hold    = cmd.fail_hold;
        wr.time_stamp   = cmd.time_stamp;
        wr.metric_kind  = cmd.metric_kind;
        wr.metric_value = cmd.metric_value;
    end

    ltps_peer_table #(
        .PEER_DEPTH (PEER_DEPTH)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_index   (scan_reg),
        .rd_kind    (kind_reg),
        .now        (stamp_reg),
        .rsp        (rsp),
        .conn_index (best_reg),
        .conn_inc   (conn_inc),
        .conn_value (conn_value)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.command == CMD_SELECT) && !fallback)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        cmd.ready        = (state_reg == S_IDLE);
        res.valid        = out_valid_reg;
        res.status       = out_status_reg;
        res.chosen_index = out_index_reg;
        res.chosen_time  = out_time_reg;
        res.chosen_conns = out_conns_reg;
        res.tried_out    = out_tried_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            metric_base_reg <= 1'b0;
            metric_mode_reg <= 1'b0;
            peer_count_reg  <= 6'd1;
            first_done_reg  <= 1'b0;
            scan_op_reg     <= 1'b0;
            status_reg      <= ST_DONE;
            pipe_vld_reg    <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_METRIC_BASE: metric_base_reg <= cfg_data[0];
                    CFG_METRIC_MODE: metric_mode_reg <= cfg_data[0];
                    CFG_PEER_COUNT:  peer_count_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept)
            begin
                scan_op_reg <= 1'b0;
                status_reg  <= ST_DONE;
                found_reg   <= 1'b0;
                if (cmd.command == CMD_SELECT)
                begin
                    if (fallback)
                    begin
                        first_done_reg <= 1'b1;
                        status_reg     <= ST_FALLBACK;
                    end
                    else
                    begin
                        scan_op_reg <= 1'b1;
                    end
                end
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end

            pipe_vld_reg <= (state_reg == S_SCAN) && !tried_reg[5'(scan_reg)];

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tried_reg <= (cmd.command == CMD_SELECT) ? cmd.tried_mask : 32'd0;
            stamp_reg <= cmd.time_stamp;
            kind_reg  <= {metric_mode_reg, metric_base_reg};
            scan_reg  <= '0;
            last_reg  <= IW'(scan_count - 6'd1);
        end
        else if ((state_reg == S_SCAN) && !last_issue)
        begin
            scan_reg <= scan_reg + IW'(1);
        end

        if (better)
        begin
            best_reg      <= scan_idx_prev_reg;
            best_time_reg <= rsp.time_val;
        end
        scan_idx_prev_reg <= scan_reg;

        if (load_out)
        begin
            if (scan_op_reg && found_reg)
            begin
                out_status_reg <= ST_CHOSEN;
                out_index_reg  <= 5'(best_reg);
                out_time_reg   <= best_time_reg;
                out_conns_reg  <= conn_new;
                out_tried_reg  <= tried_reg | (32'd1 << best_reg);
            end
            else
            begin
                out_status_reg <= scan_op_reg ? ST_BUSY : status_reg;
                out_index_reg  <= '0;
                out_time_reg   <= '0;
                out_conns_reg  <= '0;
                out_tried_reg  <= tried_reg;
            end
        end
    end

endmodule

>>> test/tb_least_time_peer_selector_unit.sv
// Self-checking testbench of the least-time peer selector with a scoreboard.
`timescale 1ns / 1ps

module tb_least_time_peer_selector_unit
    import ltps_pkg::*;
();

    localparam int NUM_PEERS = DEFAULT_MAX_PEERS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  peer_index;
        logic        peer_down;
        logic [7:0]  fail_limit;
        logic [7:0]  fail_count;
        logic [31:0] fail_hold;
        logic [31:0] time_stamp;
        logic [1:0]  metric_kind;
        logic [31:0] metric_value;
        logic [31:0] tried_mask;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  chosen_index;
        logic [31:0] chosen_time;
        logic [31:0] chosen_conns;
        logic [31:0] tried_out;
    } answer_t;

    // Peer table mirror plus the queue of answers still owed by the block.
    class selection_board;
        logic        metric_base;
        logic        metric_mode;
        logic [5:0]  peer_count;
        bit          first_done;
        logic        is_down [NUM_PEERS];
        logic [7:0]  fail_max [NUM_PEERS];
        logic [7:0]  fail_seen [NUM_PEERS];
        logic [31:0] hold_secs [NUM_PEERS];
        logic [31:0] checked_at [NUM_PEERS];
        logic [31:0] latency [NUM_PEERS*4];
        logic [31:0] conn_tally [NUM_PEERS];
        answer_t     pending_answers [$];
        int          errors;
        int          beats_by_cmd [4];
        int          answers_by_status [4];

        function new();
            metric_base = 1'b0;
            metric_mode = 1'b0;
            peer_count  = 6'd1;
            first_done  = 1'b0;
            errors      = 0;
            for (int p = 0; p < NUM_PEERS; p++) begin
                is_down[p]    = 1'b0;
                fail_max[p]   = '0;
                fail_seen[p]  = '0;
                hold_secs[p]  = '0;
                checked_at[p] = '0;
                conn_tally[p] = '0;
                for (int k = 0; k < 4; k++)
                    latency[p*4+k] = '0;
            end
            for (int k = 0; k < 4; k++) begin
                beats_by_cmd[k]      = 0;
                answers_by_status[k] = 0;
            end
        endfunction

        function void set_reg(cfg_index_t idx, logic [5:0] data);
            case (idx)
                CFG_METRIC_BASE: metric_base = data[0];
                CFG_METRIC_MODE: metric_mode = data[0];
                CFG_PEER_COUNT:  peer_count  = data;
                default: ;
            endcase
        endfunction

        function bit failed_out(int p, logic [31:0] now);
            logic [31:0] age;
            age = now - checked_at[p];
            if (fail_max[p] == 8'd0)
                return 1'b0;
            if (fail_seen[p] < fail_max[p])
                return 1'b0;
            return age <= hold_secs[p];
        endfunction

        function void note_command(cmd_beat_t b);
            answer_t     a;
            int          n;
            int          kind;
            bit          found;
            int          best;
            logic [31:0] best_t;
            a = '0;
            beats_by_cmd[b.command]++;
            if (b.command == CMD_HEALTH) begin
                if (b.peer_index < NUM_PEERS) begin
                    is_down[b.peer_index]    = b.peer_down;
                    fail_max[b.peer_index]   = b.fail_limit;
                    fail_seen[b.peer_index]  = b.fail_count;
                    hold_secs[b.peer_index]  = b.fail_hold;
                    checked_at[b.peer_index] = b.time_stamp;
                end
            end else if (b.command == CMD_METRIC) begin
                if (b.peer_index < NUM_PEERS)
                    latency[b.peer_index*4 + b.metric_kind] = b.metric_value;
            end else if (b.command == CMD_SELECT) begin
                a.tried_out = b.tried_mask;
                if (peer_count <= 6'd1 || !first_done) begin
                    first_done = 1'b1;
                    a.status   = ST_FALLBACK;
                end else begin
                    n = (peer_count > NUM_PEERS) ? NUM_PEERS : int'(peer_count);
                    if (n > 32)
                        n = 32;
                    kind   = int'(metric_base) + 2 * int'(metric_mode);
                    found  = 1'b0;
                    best   = 0;
                    best_t = '0;
                    for (int p = 0; p < n; p++) begin
                        if (!b.tried_mask[p] && !is_down[p] && !failed_out(p, b.time_stamp)
                            && (!found || latency[p*4+kind] < best_t)) begin
                            found  = 1'b1;
                            best   = p;
                            best_t = latency[p*4+kind];
                        end
                    end
                    if (!found) begin
                        a.status = ST_BUSY;
                    end else begin
                        if (conn_tally[best] != 32'hFFFF_FFFF)
                            conn_tally[best]++;
                        a.status          = ST_CHOSEN;
                        a.chosen_index    = 5'(best);
                        a.chosen_time     = best_t;
                        a.chosen_conns    = conn_tally[best];
                        a.tried_out[best] = 1'b1;
                    end
                end
            end
            answers_by_status[a.status]++;
            pending_answers.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $error("result beat with no command outstanding, status %0d", got.status);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.chosen_index !== want.chosen_index) begin
                $error("chosen_index: expected %0d, actual %0d",
                       want.chosen_index, got.chosen_index);
                errors++;
            end
            if (got.chosen_time !== want.chosen_time) begin
                $error("chosen_time: expected %0h, actual %0h",
                       want.chosen_time, got.chosen_time);
                errors++;
            end
            if (got.chosen_conns !== want.chosen_conns) begin
                $error("chosen_conns: expected %0d, actual %0d",
                       want.chosen_conns, got.chosen_conns);
                errors++;
            end
            if (got.tried_out !== want.tried_out) begin
                $error("tried_out: expected %0h, actual %0h", want.tried_out, got.tried_out);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     gap_pct;
    int                     stall_pct;
    logic [31:0]            now_sec;
    selection_board         board;

    ltps_cmd_if cmd_bus ();
    ltps_res_if res_bus ();

    least_time_peer_selector_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Result side: check every accepted beat, then decide the next cycle's ready.
    always @(posedge clk) begin
        if (res_bus.valid && res_bus.ready)
            board.check_answer({res_bus.status, res_bus.chosen_index, res_bus.chosen_time,
                                res_bus.chosen_conns, res_bus.tried_out});
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d results outstanding", board.pending_answers.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_beat(input cmd_beat_t b);
        while ($urandom_range(99) < gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= b.command;
        cmd_bus.peer_index   <= b.peer_index;
        cmd_bus.peer_down    <= b.peer_down;
        cmd_bus.fail_limit   <= b.fail_limit;
        cmd_bus.fail_count   <= b.fail_count;
        cmd_bus.fail_hold    <= b.fail_hold;
        cmd_bus.time_stamp   <= b.time_stamp;
        cmd_bus.metric_kind  <= b.metric_kind;
        cmd_bus.metric_value <= b.metric_value;
        cmd_bus.tried_mask   <= b.tried_mask;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        board.note_command(b);
    endtask

    // Hold the command side off until every owed answer has come back.
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic base, input logic mode, input logic [5:0] count);
        logic [5:0] base_word;
        logic [5:0] mode_word;
        base_word = {5'($urandom), base};
        mode_word = {5'($urandom), mode};
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_METRIC_BASE;
        cfg_data  <= base_word;
        @(posedge clk);
        cfg_index <= CFG_METRIC_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        cfg_index <= CFG_PEER_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(CFG_METRIC_BASE, base_word);
        board.set_reg(CFG_METRIC_MODE, mode_word);
        board.set_reg(CFG_PEER_COUNT, count);
    endtask

    function automatic cmd_beat_t select_beat(input logic [31:0] now, input logic [31:0] mask);
        cmd_beat_t b;
        b            = '0;
        b.command    = CMD_SELECT;
        b.time_stamp = now;
        b.tried_mask = mask;
        return b;
    endfunction

    function automatic cmd_beat_t health_beat(input logic [4:0] p, input logic down,
                                              input logic [7:0] fmax, input logic [7:0] fcnt,
                                              input logic [31:0] hold, input logic [31:0] stamp);
        cmd_beat_t b;
        b            = '0;
        b.command    = CMD_HEALTH;
        b.peer_index = p;
        b.peer_down  = down;
        b.fail_limit = fmax;
        b.fail_count = fcnt;
        b.fail_hold  = hold;
        b.time_stamp = stamp;
        return b;
    endfunction

    function automatic cmd_beat_t metric_beat(input logic [4:0] p, input logic [1:0] kind,
                                              input logic [31:0] value);
        cmd_beat_t b;
        b              = '0;
        b.command      = CMD_METRIC;
        b.peer_index   = p;
        b.metric_kind  = kind;
        b.metric_value = value;
        return b;
    endfunction

    // Mostly commands aimed at the peers in use, with times near the running clock
    // so that failure windows open and close; the rest is full-range noise.
    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int        roll;
        int        span;
        b.command      = 2'($urandom);
        b.peer_index   = 5'($urandom);
        b.peer_down    = 1'($urandom);
        b.fail_limit   = 8'($urandom);
        b.fail_count   = 8'($urandom);
        b.fail_hold    = $urandom;
        b.time_stamp   = $urandom;
        b.metric_kind  = 2'($urandom);
        b.metric_value = $urandom;
        b.tried_mask   = $urandom;
        span = (board.peer_count < 2 || board.peer_count > 32) ? 32 : int'(board.peer_count);
        now_sec += 32'($urandom_range(3));
        roll = $urandom_range(99);
        if (roll < 45) begin
            b.command = CMD_SELECT;
            if ($urandom_range(9) != 0)
                b.time_stamp = now_sec;
            case ($urandom_range(3))
                0: b.tried_mask = '0;
                1: b.tried_mask = $urandom & $urandom & $urandom;
                2: b.tried_mask = $urandom;
                default: b.tried_mask = ~(32'd1 << $urandom_range(span - 1));
            endcase
        end else if (roll < 95) begin
            if ($urandom_range(4) != 0)
                b.peer_index = 5'($urandom_range(span - 1));
            if (roll < 70) begin
                b.command = CMD_METRIC;
                if ($urandom_range(3) != 0)
                    b.metric_value = $urandom_range(50);
            end else begin
                b.command = CMD_HEALTH;
                b.peer_down = ($urandom_range(4) == 0);
                if ($urandom_range(3) != 0) begin
                    b.fail_limit = 8'($urandom_range(4));
                    b.fail_count = 8'($urandom_range(5));
                    b.fail_hold  = $urandom_range(20);
                    b.time_stamp = now_sec - 32'($urandom_range(20));
                end
            end
        end else begin
            b.command = CMD_UNUSED;
        end
        return b;
    endfunction

    initial
    begin
        logic       base_set [8];
        logic       mode_set [8];
        logic [5:0] count_set [8];
        int         gap_set [4];
        int         stall_set [4];
        base_set  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        mode_set  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        count_set = '{6'd32, 6'd4, 6'd2, 6'd63, 6'd1, 6'd17, 6'd0, 6'd33};
        gap_set   = '{0, 75, 0, 30};
        stall_set = '{0, 0, 75, 30};
        board     = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        now_sec   = $urandom;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        res_bus.ready        = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = '0;
        cmd_bus.peer_index   = '0;
        cmd_bus.peer_down    = 1'b0;
        cmd_bus.fail_limit   = '0;
        cmd_bus.fail_count   = '0;
        cmd_bus.fail_hold    = '0;
        cmd_bus.time_stamp   = '0;
        cmd_bus.metric_kind  = '0;
        cmd_bus.metric_value = '0;
        cmd_bus.tried_mask   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first select after reset falls back even with many peers configured.
        load_settings(1'b0, 1'b0, 6'd32);
        send_beat(select_beat(32'd0, 32'd0));
        send_beat('1);
        send_beat(metric_beat(5'd3, 2'd0, 32'd7));
        send_beat(metric_beat(5'd5, 2'd0, 32'd7));
        send_beat(metric_beat(5'd0, 2'd0, 32'hFFFF_FFFF));
        send_beat(metric_beat(5'd31, 2'd3, 32'd0));
        send_beat(select_beat(32'd0, ~32'h0000_0028));
        send_beat(select_beat(32'd0, ~32'h0000_0001));
        send_beat(select_beat(32'hFFFF_FFFF, 32'd0));
        send_beat(health_beat(5'd31, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(select_beat(32'd0, 32'h7FFF_FFFF));
        send_beat(select_beat(32'd0, 32'hFFFF_FFFF));
        // Failure window: excluded up to and including the timeout, usable after it.
        send_beat(health_beat(5'd2, 1'b0, 8'd3, 8'd3, 32'd10, 32'd100));
        send_beat(select_beat(32'd110, ~32'h0000_0004));
        send_beat(select_beat(32'd111, ~32'h0000_0004));
        send_beat(health_beat(5'd2, 1'b0, 8'd3, 8'd2, 32'd10, 32'd100));
        send_beat(select_beat(32'd105, ~32'h0000_0004));
        send_beat(health_beat(5'd2, 1'b0, 8'd0, 8'hFF, 32'hFFFF_FFFF, 32'd0));
        send_beat(select_beat(32'd5, ~32'h0000_0004));
        // Elapsed time wraps past zero.
        send_beat(health_beat(5'd2, 1'b0, 8'd1, 8'd1, 32'd30, 32'hFFFF_FFF0));
        send_beat(select_beat(32'd5, ~32'h0000_0004));
        send_beat(health_beat(5'd31, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0));
        send_beat(select_beat(32'd0, 32'h7FFF_FFFF));

        for (int seg = 0; seg < 8; seg++) begin
            load_settings(base_set[seg], mode_set[seg], count_set[seg]);
            gap_pct   = gap_set[seg / 2];
            stall_pct = stall_set[seg / 2];
            for (int k = 0; k < 225; k++) begin
                if (k == 110)
                    wait_drained();
                send_beat(random_beat());
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d health, %0d metric, %0d select and %0d unknown command beats",
                 board.beats_by_cmd[CMD_HEALTH], board.beats_by_cmd[CMD_METRIC],
                 board.beats_by_cmd[CMD_SELECT], board.beats_by_cmd[CMD_UNUSED]);
        $display("Selects: %0d chosen, %0d busy, %0d fallback over eight register settings",
                 board.answers_by_status[ST_CHOSEN], board.answers_by_status[ST_BUSY],
                 board.answers_by_status[ST_FALLBACK]);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> least_time_peer_selector_unit.f
rtl/core/ltps_pkg.sv
rtl/core/ltps_if.sv
rtl/core/ltps_peer_table.sv
rtl/core/least_time_peer_selector_unit.sv
test/tb_least_time_peer_selector_unit.sv
